// File: rtl/mec_pkg.sv
// Shared widths and field offsets for the mesh element area and centroid block.
package mec_pkg;

  // Coordinate width and derived datapath widths
  localparam int CB   = 24;          // coordinate bits
  localparam int DFW  = CB + 1;      // coordinate difference
  localparam int SUMW = CB + 2;      // sum of three coordinates
  localparam int PRW  = 2 * CB + 2;  // signed cross term
  localparam int TW   = 2 * CB + 3;  // signed sum of cross terms
  localparam int AMW  = 2 * CB + 1;  // sub-triangle doubled area magnitude
  localparam int ARW  = 50;          // reported area
  localparam int DVW  = 2 * CB + 3;  // divisor 3 * (a1 + a2)
  localparam int MW   = CB + 1;      // magnitude of a coordinate sum
  localparam int LOW  = MW;          // low slice of a weight
  localparam int HIW  = AMW - LOW;   // high slice of a weight
  localparam int PW   = AMW + MW;    // weighted product
  localparam int NW   = PW + 2;      // signed weighted numerator
  localparam int RW   = PW + 1;      // numerator magnitude
  localparam int QW   = CB;          // quotient bits

  // Stream payload layout
  localparam int IN_W  = 8 * CB;
  localparam int OUT_F = ARW + 2 * CB;
  localparam int OUT_W = ((OUT_F + 7) / 8) * 8;

endpackage

// File: rtl/mesh_element_area_centroid.sv
// Path from input to result: stages A to G, the divider load stage H, the divider stages, then the output register.
// Throughput: one element per cycle while the output is not stalled; the 24-stage restoring
// divider (one quotient bit per stage, x and y side by side) sets the pipeline depth.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset: synchronous, active low; clears all valid bits, no result pending.
// Quad centroids and triangle vertex means share the same divider.
module mesh_element_area_centroid (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mec_pkg::IN_W-1:0]   in_tdata,  // x0, y0, x1, y1, x2, y2, x3, y3
  input  logic                       in_tuser,  // is_quad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mec_pkg::OUT_W-1:0]  out_tdata, // area, centroid_x, centroid_y, zero pad
  output logic                       out_tuser  // degenerate
);
  import mec_pkg::*;

  logic en;

  // Stage A: differences and vertex sums
  logic signed [CB-1:0]   ix0, iy0, ix1, iy1, ix2, iy2, ix3, iy3;
  logic                   a_v_r, a_quad_r;
  logic signed [CB-1:0]   a_x0_r, a_x1_r, a_x2_r, a_x3_r;
  logic signed [DFW-1:0]  a_dy12_r, a_dy20_r, a_dy01_r, a_dy32_r, a_dy03_r;
  logic signed [DFW-1:0]  a_dx02_r, a_dy13_r, a_dx13_r, a_dy02_r;
  logic signed [SUMW-1:0] a_sx1_r, a_sx2_r, a_sy1_r, a_sy2_r;

  // Stage B: cross terms
  logic                   b_v_r, b_quad_r;
  logic signed [PRW-1:0]  b_p0_r, b_p1_r, b_p2_r, b_p3_r, b_p4_r, b_p5_r, b_p6_r, b_p7_r;
  logic signed [SUMW-1:0] b_sx1_r, b_sx2_r, b_sy1_r, b_sy2_r;

  // Stage C: doubled signed areas
  logic                   c_v_r, c_quad_r;
  logic signed [TW-1:0]   c_t1_r, c_t2_r, c_dg_r;
  logic signed [SUMW-1:0] c_sx1_r, c_sx2_r, c_sy1_r, c_sy2_r;

  // Stage D: magnitudes, weights and divisor
  logic signed [TW-1:0]   d_t1_nxt;
  logic [AMW-1:0]         d_a1, d_a2;
  logic [AMW:0]           d_asum;
  logic                   d_v_r, d_degen_r;
  logic [ARW-1:0]         d_area_r;
  logic [AMW-1:0]         d_wa1_r, d_wa2_r;
  logic [DVW-1:0]         d_d_r;
  logic [MW-1:0]          d_mx1_r, d_mx2_r, d_my1_r, d_my2_r;
  logic                   d_nx1_r, d_nx2_r, d_ny1_r, d_ny2_r;

  // Stage E: partial products
  logic                   e_v_r, e_degen_r;
  logic [ARW-1:0]         e_area_r;
  logic [DVW-1:0]         e_d_r;
  logic [2*LOW-1:0]       e_lx1_r, e_lx2_r, e_ly1_r, e_ly2_r;
  logic [HIW+MW-1:0]      e_hx1_r, e_hx2_r, e_hy1_r, e_hy2_r;
  logic                   e_nx1_r, e_nx2_r, e_ny1_r, e_ny2_r;

  // Stage F: full products
  logic                   f_v_r, f_degen_r;
  logic [ARW-1:0]         f_area_r;
  logic [DVW-1:0]         f_d_r;
  logic [PW-1:0]          f_px1_r, f_px2_r, f_py1_r, f_py2_r;
  logic                   f_nx1_r, f_nx2_r, f_ny1_r, f_ny2_r;

  // Stage G: signed numerators
  logic signed [NW-1:0]   g_sx1, g_sx2, g_sy1, g_sy2;
  logic                   g_v_r, g_degen_r;
  logic [ARW-1:0]         g_area_r;
  logic [DVW-1:0]         g_d_r;
  logic signed [NW-1:0]   g_nx_r, g_ny_r;

  // Divider pipeline: index 0 is loaded with numerator magnitudes
  logic                   dv_v_r     [0:QW];
  logic                   dv_degen_r [0:QW];
  logic [ARW-1:0]         dv_area_r  [0:QW];
  logic [DVW-1:0]         dv_d_r     [0:QW];
  logic                   dv_negx_r  [0:QW];
  logic                   dv_negy_r  [0:QW];
  logic [RW-1:0]          dv_rx_r    [0:QW];
  logic [RW-1:0]          dv_ry_r    [0:QW];
  logic [QW-1:0]          dv_qx_r    [0:QW];
  logic [QW-1:0]          dv_qy_r    [0:QW];

  // Output register
  logic                   out_v_r, out_degen_r;
  logic [ARW-1:0]         out_area_r;
  logic [CB-1:0]          out_cx_r, out_cy_r;

  // Advance the whole pipeline unless the output holds a stalled result
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // Unpack coordinates
  assign ix0 = in_tdata[0*CB +: CB];
  assign iy0 = in_tdata[1*CB +: CB];
  assign ix1 = in_tdata[2*CB +: CB];
  assign iy1 = in_tdata[3*CB +: CB];
  assign ix2 = in_tdata[4*CB +: CB];
  assign iy2 = in_tdata[5*CB +: CB];
  assign ix3 = in_tdata[6*CB +: CB];
  assign iy3 = in_tdata[7*CB +: CB];

  // Valid chain for the front stages and the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      e_v_r   <= 1'b0;
      f_v_r   <= 1'b0;
      g_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      a_v_r   <= in_tvalid;
      b_v_r   <= a_v_r;
      c_v_r   <= b_v_r;
      d_v_r   <= c_v_r;
      e_v_r   <= d_v_r;
      f_v_r   <= e_v_r;
      g_v_r   <= f_v_r;
      out_v_r <= dv_v_r[QW];
    end
  end

  // Stage A
  always_ff @(posedge clk) begin
    if (en) begin
      a_quad_r <= in_tuser;
      a_x0_r   <= ix0;
      a_x1_r   <= ix1;
      a_x2_r   <= ix2;
      a_x3_r   <= ix3;
      a_dy12_r <= DFW'(iy1) - DFW'(iy2);
      a_dy20_r <= DFW'(iy2) - DFW'(iy0);
      a_dy01_r <= DFW'(iy0) - DFW'(iy1);
      a_dy32_r <= DFW'(iy3) - DFW'(iy2);
      a_dy03_r <= DFW'(iy0) - DFW'(iy3);
      a_dx02_r <= DFW'(ix0) - DFW'(ix2);
      a_dy13_r <= DFW'(iy1) - DFW'(iy3);
      a_dx13_r <= DFW'(ix1) - DFW'(ix3);
      a_dy02_r <= DFW'(iy0) - DFW'(iy2);
      a_sx1_r  <= SUMW'(ix0) + SUMW'(ix1) + SUMW'(ix2);
      a_sx2_r  <= SUMW'(ix0) + SUMW'(ix3) + SUMW'(ix2);
      a_sy1_r  <= SUMW'(iy0) + SUMW'(iy1) + SUMW'(iy2);
      a_sy2_r  <= SUMW'(iy0) + SUMW'(iy3) + SUMW'(iy2);
    end
  end

  // Stage B
  always_ff @(posedge clk) begin
    if (en) begin
      b_quad_r <= a_quad_r;
      b_p0_r   <= a_x0_r * a_dy12_r;
      b_p1_r   <= a_x1_r * a_dy20_r;
      b_p2_r   <= a_x2_r * a_dy01_r;
      b_p3_r   <= a_x0_r * a_dy32_r;
      b_p4_r   <= a_x3_r * a_dy20_r;
      b_p5_r   <= a_x2_r * a_dy03_r;
      b_p6_r   <= a_dx02_r * a_dy13_r;
      b_p7_r   <= a_dx13_r * a_dy02_r;
      b_sx1_r  <= a_sx1_r;
      b_sx2_r  <= a_sx2_r;
      b_sy1_r  <= a_sy1_r;
      b_sy2_r  <= a_sy2_r;
    end
  end

  // Stage C
  always_ff @(posedge clk) begin
    if (en) begin
      c_quad_r <= b_quad_r;
      c_t1_r   <= TW'(b_p0_r) + TW'(b_p1_r) + TW'(b_p2_r);
      c_t2_r   <= TW'(b_p3_r) + TW'(b_p4_r) + TW'(b_p5_r);
      c_dg_r   <= TW'(b_p6_r) - TW'(b_p7_r);
      c_sx1_r  <= b_sx1_r;
      c_sx2_r  <= b_sx2_r;
      c_sy1_r  <= b_sy1_r;
      c_sy2_r  <= b_sy2_r;
    end
  end

  // Stage D: a triangle divides its vertex sum by three through the same path
  assign d_t1_nxt = c_t1_r;
  assign d_a1     = d_t1_nxt[TW-1] ? AMW'(-d_t1_nxt) : AMW'(d_t1_nxt);
  assign d_a2     = c_t2_r[TW-1] ? AMW'(-c_t2_r) : AMW'(c_t2_r);
  assign d_asum   = c_quad_r ? ((AMW+1)'(d_a1) + (AMW+1)'(d_a2)) : (AMW+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      d_degen_r <= c_quad_r && (d_asum == '0);
      d_area_r  <= c_quad_r ? (c_dg_r[TW-1] ? ARW'(-c_dg_r) : ARW'(c_dg_r)) : ARW'(d_a1);
      d_wa1_r   <= c_quad_r ? d_a1 : AMW'(1);
      d_wa2_r   <= c_quad_r ? d_a2 : '0;
      d_d_r     <= DVW'({d_asum, 1'b0}) + DVW'(d_asum);
      d_nx1_r   <= c_sx1_r[SUMW-1];
      d_nx2_r   <= c_sx2_r[SUMW-1];
      d_ny1_r   <= c_sy1_r[SUMW-1];
      d_ny2_r   <= c_sy2_r[SUMW-1];
      d_mx1_r   <= c_sx1_r[SUMW-1] ? MW'(-c_sx1_r) : MW'(c_sx1_r);
      d_mx2_r   <= c_sx2_r[SUMW-1] ? MW'(-c_sx2_r) : MW'(c_sx2_r);
      d_my1_r   <= c_sy1_r[SUMW-1] ? MW'(-c_sy1_r) : MW'(c_sy1_r);
      d_my2_r   <= c_sy2_r[SUMW-1] ? MW'(-c_sy2_r) : MW'(c_sy2_r);
    end
  end

  // Stage E: split each weight into two narrow multiplies
  always_ff @(posedge clk) begin
    if (en) begin
      e_degen_r <= d_degen_r;
      e_area_r  <= d_area_r;
      e_d_r     <= d_d_r;
      e_lx1_r   <= (2*LOW)'(d_wa1_r[LOW-1:0]) * (2*LOW)'(d_mx1_r);
      e_lx2_r   <= (2*LOW)'(d_wa2_r[LOW-1:0]) * (2*LOW)'(d_mx2_r);
      e_ly1_r   <= (2*LOW)'(d_wa1_r[LOW-1:0]) * (2*LOW)'(d_my1_r);
      e_ly2_r   <= (2*LOW)'(d_wa2_r[LOW-1:0]) * (2*LOW)'(d_my2_r);
      e_hx1_r   <= (HIW+MW)'(d_wa1_r[AMW-1:LOW]) * (HIW+MW)'(d_mx1_r);
      e_hx2_r   <= (HIW+MW)'(d_wa2_r[AMW-1:LOW]) * (HIW+MW)'(d_mx2_r);
      e_hy1_r   <= (HIW+MW)'(d_wa1_r[AMW-1:LOW]) * (HIW+MW)'(d_my1_r);
      e_hy2_r   <= (HIW+MW)'(d_wa2_r[AMW-1:LOW]) * (HIW+MW)'(d_my2_r);
      e_nx1_r   <= d_nx1_r;
      e_nx2_r   <= d_nx2_r;
      e_ny1_r   <= d_ny1_r;
      e_ny2_r   <= d_ny2_r;
    end
  end

  // Stage F: recombine partial products
  always_ff @(posedge clk) begin
    if (en) begin
      f_degen_r <= e_degen_r;
      f_area_r  <= e_area_r;
      f_d_r     <= e_d_r;
      f_px1_r   <= PW'({e_hx1_r, {LOW{1'b0}}}) + PW'(e_lx1_r);
      f_px2_r   <= PW'({e_hx2_r, {LOW{1'b0}}}) + PW'(e_lx2_r);
      f_py1_r   <= PW'({e_hy1_r, {LOW{1'b0}}}) + PW'(e_ly1_r);
      f_py2_r   <= PW'({e_hy2_r, {LOW{1'b0}}}) + PW'(e_ly2_r);
      f_nx1_r   <= e_nx1_r;
      f_nx2_r   <= e_nx2_r;
      f_ny1_r   <= e_ny1_r;
      f_ny2_r   <= e_ny2_r;
    end
  end

  // Stage G: weighted numerators with sign
  assign g_sx1 = $signed({2'b00, f_px1_r});
  assign g_sx2 = $signed({2'b00, f_px2_r});
  assign g_sy1 = $signed({2'b00, f_py1_r});
  assign g_sy2 = $signed({2'b00, f_py2_r});

  always_ff @(posedge clk) begin
    if (en) begin
      g_degen_r <= f_degen_r;
      g_area_r  <= f_area_r;
      g_d_r     <= f_d_r;
      g_nx_r    <= (f_nx1_r ? -g_sx1 : g_sx1) + (f_nx2_r ? -g_sx2 : g_sx2);
      g_ny_r    <= (f_ny1_r ? -g_sy1 : g_sy1) + (f_ny2_r ? -g_sy2 : g_sy2);
    end
  end

  // Stage H: split numerators into sign and magnitude, load the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_degen_r[0] <= g_degen_r;
      dv_area_r[0]  <= g_area_r;
      dv_d_r[0]     <= g_d_r;
      dv_negx_r[0]  <= g_nx_r[NW-1];
      dv_negy_r[0]  <= g_ny_r[NW-1];
      dv_rx_r[0]    <= g_nx_r[NW-1] ? RW'(-g_nx_r) : RW'(g_nx_r);
      dv_ry_r[0]    <= g_ny_r[NW-1] ? RW'(-g_ny_r) : RW'(g_ny_r);
      dv_qx_r[0]    <= '0;
      dv_qy_r[0]    <= '0;
    end
  end

  // Restoring divider: one quotient bit per stage, most significant first
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW:0] dsh;
    logic [RW:0] trx, try_;
    logic        gex, gey;

    assign dsh  = (RW+1)'(dv_d_r[j]) << (QW - 1 - j);
    assign trx  = {1'b0, dv_rx_r[j]} - dsh;
    assign try_ = {1'b0, dv_ry_r[j]} - dsh;
    assign gex  = !trx[RW];
    assign gey  = !try_[RW];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_degen_r[j+1] <= dv_degen_r[j];
        dv_area_r[j+1]  <= dv_area_r[j];
        dv_d_r[j+1]     <= dv_d_r[j];
        dv_negx_r[j+1]  <= dv_negx_r[j];
        dv_negy_r[j+1]  <= dv_negy_r[j];
        dv_rx_r[j+1]    <= gex ? trx[RW-1:0] : dv_rx_r[j];
        dv_ry_r[j+1]    <= gey ? try_[RW-1:0] : dv_ry_r[j];
        dv_qx_r[j+1]    <= {dv_qx_r[j][QW-2:0], gex};
        dv_qy_r[j+1]    <= {dv_qy_r[j][QW-2:0], gey};
      end
    end
  end

  // Output register: restore sign, zero the centroid of a degenerate quad
  always_ff @(posedge clk) begin
    if (en) begin
      out_degen_r <= dv_degen_r[QW];
      out_area_r  <= dv_area_r[QW];
      out_cx_r    <= dv_degen_r[QW] ? '0 :
                     (dv_negx_r[QW] ? -dv_qx_r[QW] : dv_qx_r[QW]);
      out_cy_r    <= dv_degen_r[QW] ? '0 :
                     (dv_negy_r[QW] ? -dv_qy_r[QW] : dv_qy_r[QW]);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_degen_r;
  assign out_tdata  = {{(OUT_W-OUT_F){1'b0}}, out_cy_r, out_cx_r, out_area_r};

endmodule

// File: rtl/mec_chk.sv
// Port-level checker for the mesh element area and centroid block, with its bind.
module mec_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [mec_pkg::IN_W-1:0]   in_tdata,
  input logic                       in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [mec_pkg::OUT_W-1:0]  out_tdata,
  input logic                       out_tuser
);
  import mec_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Accept input exactly when the output side can advance
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output backpressure");

  // Degenerate elements report a zero centroid
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OUT_F-1:ARW] == '0)
    else $error("degenerate result with nonzero centroid");

  // Come out of reset with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind mesh_element_area_centroid mec_chk u_mec_chk (.*);

// File: verif/mesh_element_area_centroid_test.sv
// Self-checking stream testbench for the mesh element area and centroid block.
`timescale 1ns / 100ps

module mesh_element_area_centroid_test;
  import mec_pkg::*;

  localparam int LATENCY   = 33;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 800;
  localparam logic [23:0] CMAX = 24'h7FFFFF;
  localparam logic [23:0] CMIN = 24'h800000;

  typedef struct packed {
    logic [49:0] area;
    logic [23:0] cx;
    logic [23:0] cy;
    logic        degen;
  } elem_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;

  elem_result_t expected_results[$];
  int           error_count = 0;
  int           idle_cycles = 0;

  mesh_element_area_centroid u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // x0, y0, x1, y1, x2, y2, x3, y3
    .in_tuser   (in_tuser),   // is_quad
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // area, centroid_x, centroid_y, zero pad
    .out_tuser  (out_tuser)   // degenerate
  );

  always #4 clk = ~clk;

  // Twice the signed triangle area
  function automatic longint tri2x(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
    tri2x = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
  endfunction

  function automatic longint abs64(longint v);
    abs64 = (v < 0) ? -v : v;
  endfunction

  // Truncated (a1*s1 + a2*s2) / d, exact in 128 bits
  function automatic logic [23:0] wmean(longint a1, longint s1, longint a2, longint s2,
                                        longint d);
    logic signed [127:0] num;
    logic signed [127:0] q;
    num = 128'(a1) * 128'(s1) + 128'(a2) * 128'(s2);
    q = num / 128'(d);
    wmean = q[23:0];
  endfunction

  // Predict the area and centroid of one element
  function automatic elem_result_t predict_element(logic quad, logic [IN_W-1:0] data);
    longint x[4];
    longint y[4];
    longint a1, a2, d, dg;
    elem_result_t r;
    for (int i = 0; i < 4; i++) begin
      x[i] = longint'($signed(data[48*i +: 24]));
      y[i] = longint'($signed(data[48*i+24 +: 24]));
    end
    r.degen = 1'b0;
    a1 = abs64(tri2x(x[0], y[0], x[1], y[1], x[2], y[2]));
    if (!quad) begin
      r.area = a1[49:0];
      r.cx = 24'((x[0] + x[1] + x[2]) / 3);
      r.cy = 24'((y[0] + y[1] + y[2]) / 3);
    end else begin
      a2 = abs64(tri2x(x[0], y[0], x[3], y[3], x[2], y[2]));
      dg = (x[0] - x[2]) * (y[1] - y[3]) - (x[1] - x[3]) * (y[0] - y[2]);
      d = 3 * (a1 + a2);
      r.area = 50'(abs64(dg));
      if (d == 0) begin
        r.degen = 1'b1;
        r.cx = '0;
        r.cy = '0;
      end else begin
        r.cx = wmean(a1, x[0] + x[1] + x[2], a2, x[0] + x[3] + x[2], d);
        r.cy = wmean(a1, y[0] + y[1] + y[2], a2, y[0] + y[3] + y[2], d);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // No gap half the time, a short gap mostly otherwise, a long one now and then
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Send one element as an input transaction; drop valid only across a gap
  task automatic send_element(logic quad, logic [IN_W-1:0] data);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= quad;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results = {expected_results, predict_element(quad, data)};
  endtask

  function automatic logic [IN_W-1:0] pack_verts(logic [23:0] c[8]);
    logic [IN_W-1:0] v;
    for (int i = 0; i < 8; i++) v[24*i +: 24] = c[i];
    return v;
  endfunction

  function automatic logic [23:0] rand_coord(bit narrow);
    int p;
    p = $urandom_range(9);
    if (p == 0) return CMAX;
    if (p == 1) return CMIN;
    if (narrow) return 24'($signed($urandom_range(8000)) - 4000);
    return 24'($urandom);
  endfunction

  // Extremes, degenerate shapes and ignored vertex 3
  task automatic test_directed();
    logic [23:0] c[8];
    c = '{default: 24'h0};
    send_element(1'b0, pack_verts(c));
    send_element(1'b1, pack_verts(c));
    c = '{default: CMAX};
    send_element(1'b0, pack_verts(c));
    send_element(1'b1, pack_verts(c));
    c = '{default: CMIN};
    send_element(1'b0, pack_verts(c));
    send_element(1'b1, pack_verts(c));
    c = '{CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX};
    send_element(1'b0, pack_verts(c));
    send_element(1'b1, pack_verts(c));
    c = '{CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN};
    send_element(1'b0, pack_verts(c));
    send_element(1'b1, pack_verts(c));
    // unit square, in both windings
    c = '{24'd0, 24'd0, 24'd256, 24'd0, 24'd256, 24'd256, 24'd0, 24'd256};
    send_element(1'b1, pack_verts(c));
    c = '{24'd0, 24'd0, 24'd0, 24'd256, 24'd256, 24'd256, 24'd256, 24'd0};
    send_element(1'b1, pack_verts(c));
    // collinear quad: zero sub-triangle areas
    c = '{24'd10, 24'd10, 24'd20, 24'd20, 24'd30, 24'd30, 24'd40, 24'd40};
    send_element(1'b1, pack_verts(c));
    // zero-area triangle keeps its vertex mean; vertex 3 is don't-care
    c = '{-24'sd5, -24'sd5, -24'sd7, -24'sd7, 24'd1, 24'd1, CMAX, CMIN};
    send_element(1'b0, pack_verts(c));
    // negative sums to check truncation toward zero
    c = '{-24'sd1, -24'sd2, -24'sd1, 24'd0, 24'd0, -24'sd1, -24'sd3, 24'd5};
    send_element(1'b0, pack_verts(c));
    send_element(1'b1, pack_verts(c));
    // alternating bit patterns, each bit high in one and low in the other
    c = '{default: 24'hAAAAAA};
    send_element(1'b1, pack_verts(c));
    c = '{default: 24'h555555};
    send_element(1'b0, pack_verts(c));
  endtask

  // Random elements: narrow and full range, some degenerate
  task automatic test_random();
    logic [23:0] c[8];
    bit narrow;
    for (int n = 0; n < N_RANDOM; n++) begin
      narrow = ($urandom_range(1) == 0);
      for (int i = 0; i < 8; i++) c[i] = rand_coord(narrow);
      if ($urandom_range(19) == 0) begin
        c[2] = c[0]; c[3] = c[1]; c[6] = c[0]; c[7] = c[1];
      end
      send_element(1'(($urandom)), pack_verts(c));
    end
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    elem_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transaction", out_tdata[49:0], 0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[49:0] !== want.area)
          report_mismatch("area", out_tdata[49:0], want.area);
        if (out_tdata[73:50] !== want.cx)
          report_mismatch("centroid_x", out_tdata[73:50], want.cx);
        if (out_tdata[97:74] !== want.cy)
          report_mismatch("centroid_y", out_tdata[97:74], want.cy);
        if (out_tuser !== want.degen)
          report_mismatch("degenerate", out_tuser, want.degen);
      end
    end
  end

  // Random output stall, mostly short with a long one now and then
  always @(posedge clk) begin
    int p;
    int stall_left;
    p = $urandom_range(99);
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (p < 3) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(40, 10);
    end else if (p < 65) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
